[src/wsenc_pkg.sv]
// Shared types, constants and header byte functions of the WebSocket frame encoder.
package wsenc_pkg;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  localparam int unsigned LEN_W  = 63;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned S_DATA_W = 104;

  localparam logic [7:0]       HDR_FIN_TEXT = 8'h81;
  localparam logic [7:0]       HDR_MASK_BIT = 8'h80;
  localparam logic [6:0]       LEN_CODE_16  = 7'd126;
  localparam logic [6:0]       LEN_CODE_64  = 7'd127;
  localparam logic [LEN_W-1:0] LEN7_MAX     = 63'd125;
  localparam logic [LEN_W-1:0] LEN16_MAX    = 63'hffff;

  typedef enum logic {
    CMD_HEADER,
    CMD_PAYLOAD
  } cmd_kind_e;

  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_MID,
    LEN_LONG
  } len_class_e;

  typedef struct packed {
    cmd_kind_e         kind;
    len_class_e        cls;
    logic              flag;
    logic [LEN_W-1:0]  len;
    logic [KEY_W-1:0]  key;
  } wsenc_cmd_t;

  function automatic logic [3:0] hdr_last_idx(input len_class_e cls);
    logic [3:0] r;
    unique case (cls)
      LEN_SHORT: r = 4'd5;
      LEN_MID:   r = 4'd7;
      default:   r = 4'd13;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hdr_byte(input wsenc_cmd_t c, input logic [3:0] idx);
    logic [3:0]  last;
    logic [3:0]  koff;
    logic [3:0]  loff;
    logic [63:0] len64;
    logic [7:0]  b;
    last  = hdr_last_idx(c.cls);
    len64 = {1'b0, c.len};
    koff  = idx - (last - 4'd3);
    loff  = 4'd9 - idx;
    if (idx == 4'd0) begin
      b = HDR_FIN_TEXT;
    end else if (idx == 4'd1) begin
      unique case (c.cls)
        LEN_SHORT: b = HDR_MASK_BIT | {1'b0, c.len[6:0]};
        LEN_MID:   b = HDR_MASK_BIT | {1'b0, LEN_CODE_16};
        default:   b = HDR_MASK_BIT | {1'b0, LEN_CODE_64};
      endcase
    end else if (idx > (last - 4'd4)) begin
      b = c.key[{koff[1:0], 3'b000} +: 8];
    end else if (c.cls == LEN_MID) begin
      b = (idx == 4'd2) ? c.len[15:8] : c.len[7:0];
    end else begin
      b = len64[{loff[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

[src/websocket_client_frame_encoder_unit.sv]
// Top level of the masked WebSocket client frame encoder.
// An accepted item is written into the command queue; its first result byte is then registered in the output register.
// Throughput: one payload item per cycle while the output is not stalled; a start item emits 6, 8 or 14 header
// bytes at one byte per cycle from the back end unless the output stalls, while the front end keeps
// taking items into a QUEUE_DEPTH-entry command queue until it is full.
// Reset: asynchronous, active low; clears frame state, empties the queue, drops output.
module websocket_client_frame_encoder_unit
  import wsenc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // frame_length[62:0], mask_key[94:63], data_byte[102:95]
  input  logic                s_axis_tuser,  // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // out_byte[7:0]
  output logic                m_axis_tuser,  // run_last
  output logic                m_axis_tlast   // frame_last
);

  logic       push;
  wsenc_cmd_t push_cmd;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  wsenc_cmd_t head_cmd;

  wsenc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .func_i         (s_axis_tuser),
    .frame_length_i (s_axis_tdata[62:0]),
    .mask_key_i     (s_axis_tdata[94:63]),
    .data_byte_i    (s_axis_tdata[102:95]),
    .in_ready_o     (s_axis_tready),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  wsenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  wsenc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .run_last_o   (m_axis_tuser),
    .frame_last_o (m_axis_tlast)
  );

endmodule

[src/wsenc_front.sv]
// Front end: accept items, track the open frame, mask payload bytes, issue commands.
module wsenc_front
  import wsenc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              func_i,
  input  logic [LEN_W-1:0]  frame_length_i,
  input  logic [KEY_W-1:0]  mask_key_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output wsenc_cmd_t        cmd_o
);

  logic [KEY_W-1:0] held_mask_q, held_mask_d;
  logic [1:0]       mask_pos_q, mask_pos_d;
  logic [LEN_W-1:0] remain_q, remain_d;
  logic             open_q, open_d;
  logic             accept;
  logic [LEN_W-1:0] remain_dec;
  logic [7:0]       mask_byte;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign remain_dec = remain_q - 63'd1;
  assign mask_byte  = held_mask_q[{mask_pos_q, 3'b000} +: 8];

  always_comb begin
    held_mask_d = held_mask_q;
    mask_pos_d  = mask_pos_q;
    remain_d    = remain_q;
    open_d      = open_q;
    push_o      = 1'b0;
    cmd_o.kind  = CMD_HEADER;
    cmd_o.cls   = LEN_SHORT;
    cmd_o.flag  = 1'b0;
    cmd_o.len   = frame_length_i;
    cmd_o.key   = mask_key_i;
    if (frame_length_i > LEN16_MAX) begin
      cmd_o.cls = LEN_LONG;
    end else if (frame_length_i > LEN7_MAX) begin
      cmd_o.cls = LEN_MID;
    end
    if (accept) begin
      if (func_i == FUNC_START) begin
        held_mask_d = mask_key_i;
        mask_pos_d  = 2'd0;
        remain_d    = frame_length_i;
        open_d      = (frame_length_i != '0);
        push_o      = 1'b1;
        cmd_o.flag  = (frame_length_i == '0);
      end else if (open_q) begin
        mask_pos_d     = mask_pos_q + 2'd1;
        remain_d       = remain_dec;
        open_d         = (remain_dec != '0);
        push_o         = 1'b1;
        cmd_o.kind     = CMD_PAYLOAD;
        cmd_o.flag     = (remain_dec == '0);
        cmd_o.key      = {{(KEY_W-BYTE_W){1'b0}}, data_byte_i ^ mask_byte};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mask_q <= '0;
      mask_pos_q  <= '0;
      remain_q    <= '0;
      open_q      <= 1'b0;
    end else begin
      held_mask_q <= held_mask_d;
      mask_pos_q  <= mask_pos_d;
      remain_q    <= remain_d;
      open_q      <= open_d;
    end
  end

endmodule

[src/wsenc_queue.sv]
// Command queue between front end and byte emitter.
module wsenc_queue
  import wsenc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  wsenc_cmd_t cmd_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output wsenc_cmd_t cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wsenc_cmd_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

[src/wsenc_back.sv]
// Back end: expand commands into header and payload bytes behind an output register.
module wsenc_back
  import wsenc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  wsenc_cmd_t cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_last_o
);

  logic       busy_q;
  logic [3:0] idx_q;
  wsenc_cmd_t cur_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_last_q;
  logic       frame_last_q;
  logic       adv;
  logic       hdr_end;

  assign adv     = !out_valid_q || out_ready_i;
  assign pop_o   = adv && !busy_q && q_valid_i;
  assign hdr_end = (idx_q == hdr_last_idx(cur_q.cls));

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign frame_last_o = frame_last_q;

  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.kind == CMD_HEADER) begin
      cur_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      run_last_q   <= 1'b0;
      frame_last_q <= 1'b0;
    end else if (adv) begin
      if (busy_q) begin
        out_valid_q  <= 1'b1;
        out_byte_q   <= hdr_byte(cur_q, idx_q);
        run_last_q   <= hdr_end;
        frame_last_q <= hdr_end && cur_q.flag;
        if (hdr_end) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 4'd1;
        end
      end else if (q_valid_i) begin
        out_valid_q <= 1'b1;
        unique case (cmd_i.kind)
          CMD_PAYLOAD: begin
            out_byte_q   <= cmd_i.key[7:0];
            run_last_q   <= 1'b1;
            frame_last_q <= cmd_i.flag;
          end
          default: begin
            out_byte_q   <= HDR_FIN_TEXT;
            run_last_q   <= 1'b0;
            frame_last_q <= 1'b0;
            busy_q       <= 1'b1;
            idx_q        <= 4'd1;
          end
        endcase
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[src/wsenc_checker.sv]
// Port-level checks of the frame encoder, bound to the top level.
module wsenc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  a_frame_end_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("frame end without run end");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid)
    else $error("gap inside a header run");

endmodule

bind websocket_client_frame_encoder_unit wsenc_checker u_wsenc_checker (.*);
